@@ hdl/sbc_pkg.sv @@
// shared constants and helpers for the seconds to bcd calendar converter
`default_nettype none
package sbc_pkg;

  localparam int SECS_W  = 32;
  localparam int SEC_W   = 7;
  localparam int MIN_W   = 7;
  localparam int HOUR_W  = 6;
  localparam int DAY_W   = 6;
  localparam int MONTH_W = 5;
  localparam int YEAR_W  = 8;

  // first second of 2100-01-01
  localparam logic [31:0] SECS_TO_2100 = 32'd3155760000;

  // reciprocal constants, exact for any 32-bit dividend unless a smaller range is noted
  localparam logic [31:0] MAG_DIV60   = 32'h8888_8889;  // shift 37
  localparam logic [31:0] MAG_DIV24   = 32'hAAAA_AAAB;  // shift 36
  localparam logic [20:0] MAG_DIV1461 = 21'd1469873;    // shift 31, days below 2^16

  localparam logic [10:0] DAYS_4Y = 11'd1461;
  localparam logic [10:0] END_Y0  = 11'd366;
  localparam logic [10:0] END_Y1  = 11'd731;
  localparam logic [10:0] END_Y2  = 11'd1096;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // day of year at which a month starts
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    begin
      case (m)
        4'd1:    base = 9'd0;
        4'd2:    base = 9'd31;
        4'd3:    base = 9'd59;
        4'd4:    base = 9'd90;
        4'd5:    base = 9'd120;
        4'd6:    base = 9'd151;
        4'd7:    base = 9'd181;
        4'd8:    base = 9'd212;
        4'd9:    base = 9'd243;
        4'd10:   base = 9'd273;
        4'd11:   base = 9'd304;
        4'd12:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (m > MONTH_FEB)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

  // binary 0..99 to packed bcd
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    begin
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      return 8'(v) + 8'(tens) * 8'd6;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/sbc_ifs.sv @@
// item channels of the seconds to bcd calendar converter
`default_nettype none
interface sbc_in_if;
  import sbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SECS_W-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface sbc_out_if;
  import sbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEC_W-1:0]   second_bcd;
  logic [MIN_W-1:0]   minute_bcd;
  logic [HOUR_W-1:0]  hour_bcd;
  logic [DAY_W-1:0]   day_bcd;
  logic [MONTH_W-1:0] month_bcd;
  logic [YEAR_W-1:0]  year_bcd;
  logic               out_of_range;

  modport source (output valid, output second_bcd, output minute_bcd, output hour_bcd,
                  output day_bcd, output month_bcd, output year_bcd, output out_of_range,
                  input ready);
  modport sink   (input valid, input second_bcd, input minute_bcd, input hour_bcd,
                  input day_bcd, input month_bcd, input year_bcd, input out_of_range,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/seconds_to_bcd_calendar.sv @@
// seconds since 2000-01-01 to bcd calendar fields, eight-stage pipeline
//
// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into packed
// bcd second, minute, hour, day, month and two-digit year. A new item may
// enter every cycle; the pipeline advances as a whole, so it stops only
// while the final result register holds an item that the sink has not
// taken. The stages are: three reciprocal multiplies (by 60, 60, 24), a
// split into four-year groups, year within the group, a month search over a
// constant table, and the day subtraction with bcd conversion. Inputs at or
// beyond 2100-01-01 give out_of_range with all other fields zero.
`default_nettype none
module seconds_to_bcd_calendar (
  input  wire         clk,
  input  wire         rst_n,
  sbc_in_if.sink      in_ch,
  sbc_out_if.source   out_ch
);
  import sbc_pkg::*;

  logic en;

  // stage valids
  logic [7:0] v_r;

  // stage 1
  logic        oor1_r;
  logic [26:0] q1_r;
  logic [5:0]  t1lo_r;
  logic [63:0] p1;

  // stage 2
  logic        oor2_r;
  logic [21:0] q2_r;
  logic [5:0]  q1lo_r;
  logic [5:0]  ss2_r;
  logic [63:0] p2;

  // stage 3
  logic        oor3_r;
  logic [17:0] days3_r;
  logic [4:0]  q2lo_r;
  logic [5:0]  ss3_r, mm3_r;
  logic [63:0] p3;

  // stage 4
  logic        oor4_r;
  logic [4:0]  g4_r;
  logic [15:0] days4_r;
  logic [5:0]  ss4_r, mm4_r;
  logic [4:0]  hh4_r;
  logic [36:0] p4;

  // stage 5
  logic        oor5_r;
  logic [4:0]  g5_r;
  logic [10:0] r5_r;
  logic [5:0]  ss5_r, mm5_r;
  logic [4:0]  hh5_r;
  logic [15:0] gm5;

  // stage 6
  logic        oor6_r, leap6_r;
  logic [6:0]  year6_r;
  logic [8:0]  doy6_r;
  logic [5:0]  ss6_r, mm6_r;
  logic [4:0]  hh6_r;
  logic [1:0]  yoff_nxt;
  logic [10:0] doy6_nxt;

  // stage 7
  logic        oor7_r, leap7_r;
  logic [6:0]  year7_r;
  logic [8:0]  doy7_r;
  logic [3:0]  month7_r;
  logic [5:0]  ss7_r, mm7_r;
  logic [4:0]  hh7_r;
  logic [3:0]  month_nxt;

  // stage 8, output register
  logic [SEC_W-1:0]   sec_r;
  logic [MIN_W-1:0]   min_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic               oor_r;
  logic [4:0]         day_nxt;

  assign en          = !v_r[7] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_ch.valid};
    end
  end

  assign p1 = 64'(in_ch.seconds_since_epoch) * 64'(MAG_DIV60);
  assign p2 = 64'(q1_r) * 64'(MAG_DIV60);
  assign p3 = 64'(q2_r) * 64'(MAG_DIV24);
  assign p4 = 37'(days3_r[15:0]) * 37'(MAG_DIV1461);
  assign gm5 = 16'(g4_r) * 16'(DAYS_4Y);

  always_comb begin
    if (r5_r < END_Y0) begin
      yoff_nxt = 2'd0;
      doy6_nxt = r5_r;
    end else if (r5_r < END_Y1) begin
      yoff_nxt = 2'd1;
      doy6_nxt = r5_r - END_Y0;
    end else if (r5_r < END_Y2) begin
      yoff_nxt = 2'd2;
      doy6_nxt = r5_r - END_Y1;
    end else begin
      yoff_nxt = 2'd3;
      doy6_nxt = r5_r - END_Y2;
    end
  end

  // month = 1 + number of later month starts already reached
  always_comb begin
    month_nxt = MONTH_JAN;
    for (int i = 2; i <= 12; i++) begin
      if (doy6_r >= month_start(4'(i), leap6_r)) begin
        month_nxt = month_nxt + 4'd1;
      end
    end
  end

  assign day_nxt = 5'(doy7_r - month_start(month7_r, leap7_r)) + 5'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      oor1_r  <= in_ch.seconds_since_epoch >= SECS_TO_2100;
      q1_r    <= p1[63:37];
      t1lo_r  <= in_ch.seconds_since_epoch[5:0];

      oor2_r  <= oor1_r;
      q2_r    <= p2[58:37];
      q1lo_r  <= q1_r[5:0];
      ss2_r   <= 6'(t1lo_r - 6'(q1_r[5:0] * 6'd60));

      oor3_r  <= oor2_r;
      days3_r <= p3[53:36];
      q2lo_r  <= q2_r[4:0];
      ss3_r   <= ss2_r;
      mm3_r   <= 6'(q1lo_r - 6'(q2_r[5:0] * 6'd60));

      oor4_r  <= oor3_r;
      g4_r    <= p4[35:31];
      days4_r <= days3_r[15:0];
      ss4_r   <= ss3_r;
      mm4_r   <= mm3_r;
      hh4_r   <= 5'(q2lo_r - 5'(days3_r[4:0] * 5'd24));

      oor5_r  <= oor4_r;
      g5_r    <= g4_r;
      r5_r    <= 11'(days4_r - gm5);
      ss5_r   <= ss4_r;
      mm5_r   <= mm4_r;
      hh5_r   <= hh4_r;

      oor6_r  <= oor5_r;
      leap6_r <= yoff_nxt == 2'd0;
      year6_r <= {g5_r, yoff_nxt};
      doy6_r  <= doy6_nxt[8:0];
      ss6_r   <= ss5_r;
      mm6_r   <= mm5_r;
      hh6_r   <= hh5_r;

      oor7_r   <= oor6_r;
      leap7_r  <= leap6_r;
      year7_r  <= year6_r;
      doy7_r   <= doy6_r;
      month7_r <= month_nxt;
      ss7_r    <= ss6_r;
      mm7_r    <= mm6_r;
      hh7_r    <= hh6_r;

      oor_r <= oor7_r;
      if (oor7_r) begin
        sec_r   <= '0;
        min_r   <= '0;
        hour_r  <= '0;
        day_r   <= '0;
        month_r <= '0;
        year_r  <= '0;
      end else begin
        sec_r   <= SEC_W'(to_bcd(7'(ss7_r)));
        min_r   <= MIN_W'(to_bcd(7'(mm7_r)));
        hour_r  <= HOUR_W'(to_bcd(7'(hh7_r)));
        day_r   <= DAY_W'(to_bcd(7'(day_nxt)));
        month_r <= MONTH_W'(to_bcd(7'(month7_r)));
        year_r  <= to_bcd(year7_r);
      end
    end
  end

  assign out_ch.valid        = v_r[7];
  assign out_ch.second_bcd   = sec_r;
  assign out_ch.minute_bcd   = min_r;
  assign out_ch.hour_bcd     = hour_r;
  assign out_ch.day_bcd      = day_r;
  assign out_ch.month_bcd    = month_r;
  assign out_ch.year_bcd     = year_r;
  assign out_ch.out_of_range = oor_r;

  // out of range result carries zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |->
      (out_ch.second_bcd == '0 && out_ch.minute_bcd == '0 && out_ch.hour_bcd == '0 &&
       out_ch.day_bcd == '0 && out_ch.month_bcd == '0 && out_ch.year_bcd == '0))
    else $error("out of range result with nonzero fields");

  // in-range result has a real day and month
  a_day_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.out_of_range) |->
      (out_ch.day_bcd != '0 && out_ch.month_bcd != '0 && out_ch.month_bcd <= 5'h12))
    else $error("day or month out of range");

  // a stall freezes every stage valid
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved during stall");

  // a result waiting on the sink holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.second_bcd) && $stable(out_ch.minute_bcd) &&
       $stable(out_ch.hour_bcd) && $stable(out_ch.day_bcd) &&
       $stable(out_ch.month_bcd) && $stable(out_ch.year_bcd) &&
       $stable(out_ch.out_of_range)))
    else $error("result changed while waiting");

  // hours below 24
  a_hour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.out_of_range) |-> (out_ch.hour_bcd <= 6'h23))
    else $error("hour out of range");

endmodule
`default_nettype wire
